// ----- rtl/kuf_pkg.sv -----
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared widths, result codes, controller states and the totals control word
// for the Kruskal union-find edge filter.
// ----------------------------------------------------------------------------
package kuf_pkg;

	// field widths
	localparam int VERT_W   = 8;
	localparam int WEIGHT_W = 16;
	localparam int VC_W     = 9;
	localparam int CODE_W   = 3;
	localparam int COUNT_W  = 8;
	localparam int SUM_W    = 24;
	localparam int RANK_W   = 4;

	// defaults
	localparam int MAX_VERTICES_DEF = 256;
	localparam logic [VC_W-1:0] VC_RESET = 9'd256;
	localparam logic [RANK_W-1:0] RANK_MAX = '1;

	// opcodes
	localparam logic OP_EDGE  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// result codes
	localparam logic [CODE_W-1:0] RES_ACCEPT = 3'd0;
	localparam logic [CODE_W-1:0] RES_SAME   = 3'd1;
	localparam logic [CODE_W-1:0] RES_DONE   = 3'd2;
	localparam logic [CODE_W-1:0] RES_RANGE  = 3'd3;
	localparam logic [CODE_W-1:0] RES_CLEAR  = 3'd4;

	// controller states
	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_FIND_RD,
		S_FIND_CHK,
		S_COMP_RD,
		S_COMP_WR,
		S_MERGE_A,
		S_MERGE_B,
		S_REPORT
	} kuf_state_t;

	// totals control
	typedef struct packed {
		logic clr;
		logic add;
	} kuf_tot_ctrl_t;

endpackage

// ----- rtl/kuf_forest_mem.sv -----
// ----------------------------------------------------------------------------
// kuf_forest_mem
// Forest store: one entry per vertex holding {rank, parent}. One write port,
// one read port, read data registered.
// ----------------------------------------------------------------------------
module kuf_forest_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 12
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/kuf_totals.sv -----
// ----------------------------------------------------------------------------
// kuf_totals
// Accepted edge count and weight sum, plus the tree complete flag against
// the effective vertex count.
// ----------------------------------------------------------------------------
module kuf_totals
	import kuf_pkg::*;
#(
	parameter int EW = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kuf_tot_ctrl_t       ctrl,
	input  logic [WEIGHT_W-1:0] weight,
	input  logic [EW-1:0]       eff_n,
	output logic [COUNT_W-1:0]  count,
	output logic [SUM_W-1:0]    sum,
	output logic                full
);

	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_q;

	// running totals, wrap at their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (ctrl.clr) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (ctrl.add) begin
			count_q <= count_q + COUNT_W'(1);
			sum_q   <= sum_q + SUM_W'(weight);
		end
	end

	assign count = count_q;
	assign sum   = sum_q;
	// eff_n is at least one, so eff_n-1 never underflows
	assign full  = (EW'(count_q) >= (eff_n - EW'(1)));

endmodule

// ----- rtl/kruskal_union_find_edge_filter.sv -----
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// Kruskal acceptance test over a disjoint-set forest (union by rank, full path
// compression) kept in one single-port-per-direction memory.
//
// Sequence: complete/out-of-range edges go straight from idle to report.
//   Offered edges, per endpoint, read and check one node per find step, then
//   compress the path (read, write per node, then a root check); then merge
//   (one or two writes, none on reject) and report; a clear sweeps the forest.
// Throughput: one item at a time; busy stays high until the result strobe.
//   Every step is bound by the single forest memory read/write per cycle.
// Reset: a sweep of all MAX_VERTICES entries rewrites the forest (busy high);
//   the receiver cannot stall, done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_filter
	import kuf_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// command channel
	input  logic                start,
	output logic                busy,
	input  logic                opcode,
	input  logic [VERT_W-1:0]   u_vertex,
	input  logic [VERT_W-1:0]   v_vertex,
	input  logic [WEIGHT_W-1:0] edge_weight,
	// configuration channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [VC_W-1:0]     vertex_count,
	// result
	output logic                done,
	output logic [CODE_W-1:0]   result_code,
	output logic [COUNT_W-1:0]  accepted_count,
	output logic [SUM_W-1:0]    total_weight,
	output logic                tree_done
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int DW = RANK_W + AW;
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int EW = (NW > VC_W) ? NW : VC_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

	kuf_state_t state_q, state_d;

	logic [VC_W-1:0]     vc_q;
	logic [EW-1:0]       eff_n;
	logic                full;
	kuf_tot_ctrl_t       tot_ctrl;

	logic [AW-1:0]       node_q, start_q, v_q;
	logic [AW-1:0]       ru_q, rv_q;
	logic [RANK_W-1:0]   rku_q, rkv_q;
	logic                phase_q;
	logic                report_clr_q;
	logic [AW-1:0]       sweep_q;
	logic [CODE_W-1:0]   code_q;
	logic [WEIGHT_W-1:0] w_q;

	logic [DW-1:0]       rd_data;
	logic [AW-1:0]       rd_parent;
	logic [RANK_W-1:0]   rd_rank;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [DW-1:0]       mem_wdata;

	logic                out_range;
	logic                at_root;
	logic [AW-1:0]       cur_root;
	logic [RANK_W-1:0]   rku_inc;

	// configuration register, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vc_q <= vertex_count;
		end
	end

	// effective vertex count: zero acts as one, clipped to the table depth
	always_comb begin
		if (vc_q == '0) begin
			eff_n = EW'(1);
		end else if (EW'(vc_q) > EW'(MAX_VERTICES)) begin
			eff_n = EW'(MAX_VERTICES);
		end else begin
			eff_n = EW'(vc_q);
		end
	end

	assign out_range = (EW'(u_vertex) >= eff_n) || (EW'(v_vertex) >= eff_n);
	assign rd_parent = rd_data[AW-1:0];
	assign rd_rank   = rd_data[DW-1:AW];
	assign cur_root  = phase_q ? rv_q : ru_q;
	assign at_root   = (node_q == cur_root);
	assign rku_inc   = (rku_q == RANK_MAX) ? rku_q : rku_q + RANK_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP: begin
				if (sweep_q == LAST_ADDR) begin
					state_d = report_clr_q ? S_REPORT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					priority if (opcode == OP_CLEAR) begin
						state_d = S_SWEEP;
					end else if (full || out_range) begin
						state_d = S_REPORT;
					end else begin
						state_d = S_FIND_RD;
					end
				end
			end
			S_FIND_RD: state_d = S_FIND_CHK;
			S_FIND_CHK: begin
				state_d = (rd_parent == node_q) ? S_COMP_RD : S_FIND_RD;
			end
			S_COMP_RD: begin
				priority if (!at_root) begin
					state_d = S_COMP_WR;
				end else if (!phase_q) begin
					state_d = S_FIND_RD;
				end else if (ru_q == rv_q) begin
					state_d = S_REPORT;
				end else begin
					state_d = S_MERGE_A;
				end
			end
			S_COMP_WR: state_d = S_COMP_RD;
			S_MERGE_A: state_d = (rku_q == rkv_q) ? S_MERGE_B : S_REPORT;
			S_MERGE_B: state_d = S_REPORT;
			S_REPORT:  state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// state-decoded outputs: memory writes, totals control, handshake
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = node_q;
		mem_wdata = {rd_rank, cur_root};
		tot_ctrl  = '0;
		busy      = (state_q != S_IDLE);
		done      = (state_q == S_REPORT);
		unique case (state_q)
			S_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = {{RANK_W{1'b0}}, sweep_q};
			end
			S_IDLE: begin
				tot_ctrl.clr = start && (opcode == OP_CLEAR);
			end
			S_COMP_WR: begin
				// point the node straight at its root, keep its rank
				mem_we = 1'b1;
			end
			S_MERGE_A: begin
				mem_we       = 1'b1;
				tot_ctrl.add = 1'b1;
				priority if (rku_q == rkv_q) begin
					mem_waddr = ru_q;
					mem_wdata = {rku_inc, ru_q};
				end else if (rku_q > rkv_q) begin
					mem_waddr = rv_q;
					mem_wdata = {rkv_q, ru_q};
				end else begin
					mem_waddr = ru_q;
					mem_wdata = {rku_q, rv_q};
				end
			end
			S_MERGE_B: begin
				mem_we    = 1'b1;
				mem_waddr = rv_q;
				mem_wdata = {rkv_q, ru_q};
			end
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= '0;
			report_clr_q <= 1'b0;
		end else if (state_q == S_IDLE && start && opcode == OP_CLEAR) begin
			sweep_q      <= '0;
			report_clr_q <= 1'b1;
		end else if (state_q == S_SWEEP) begin
			sweep_q <= sweep_q + AW'(1);
		end
	end

	// find / compress datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_SWEEP: begin
				code_q <= RES_CLEAR;
			end
			S_IDLE: begin
				if (start) begin
					priority if (opcode == OP_CLEAR) begin
						code_q <= RES_CLEAR;
					end else if (full) begin
						code_q <= RES_DONE;
					end else begin
						code_q <= RES_RANGE;
					end
				end
				node_q  <= AW'(u_vertex);
				start_q <= AW'(u_vertex);
				v_q     <= AW'(v_vertex);
				w_q     <= edge_weight;
				phase_q <= 1'b0;
			end
			S_FIND_CHK: begin
				if (rd_parent == node_q) begin
					if (phase_q) begin
						rv_q  <= node_q;
						rkv_q <= rd_rank;
					end else begin
						ru_q  <= node_q;
						rku_q <= rd_rank;
					end
					node_q <= start_q;
				end else begin
					node_q <= rd_parent;
				end
			end
			S_COMP_RD: begin
				if (at_root) begin
					if (!phase_q) begin
						phase_q <= 1'b1;
						node_q  <= v_q;
						start_q <= v_q;
					end else begin
						code_q <= RES_SAME;
					end
				end
			end
			S_COMP_WR: begin
				node_q <= rd_parent;
			end
			S_MERGE_A: begin
				code_q <= RES_ACCEPT;
			end
			default: begin
			end
		endcase
	end

	// forest memory
	kuf_forest_mem #(
		.DEPTH(MAX_VERTICES),
		.AW   (AW),
		.DW   (DW)
	) u_mem (
		.clk    (clk),
		.rd_addr(node_q),
		.rd_data(rd_data),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata)
	);

	// running totals
	kuf_totals #(
		.EW(EW)
	) u_totals (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (tot_ctrl),
		.weight(w_q),
		.eff_n (eff_n),
		.count (accepted_count),
		.sum   (total_weight),
		.full  (full)
	);

	assign result_code = code_q;
	assign tree_done   = full;

endmodule
